// ----- rtl/pes_pkg.sv -----
// pes_pkg: shared types, codes and sizes of the postfix stack evaluator.
// Used by pes_muldiv and postfix_stack_evaluator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pes_pkg;

   localparam int DATA_W      = 32;
   localparam int IMM_W       = 16;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int STACK_DEPTH = 16;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int REQ_DATA_W  = IMM_W + 2 * DATA_W;
   localparam int MD_STEPS    = DATA_W;
   localparam int MD_CNT_W    = $clog2(MD_STEPS);

   // instruction kinds
   localparam logic [KIND_W-1:0] KIND_END   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_VAR   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SHORT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OP    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LONG  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STS_LEADING_OP = 3'd1;
   localparam logic [STATUS_W-1:0] STS_BAD_OP     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_BAD_KIND   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW  = 3'd5;
   localparam logic [STATUS_W-1:0] STS_DIV_ZERO   = 3'd6;

   // operator codes (ASCII)
   localparam logic [IMM_W-1:0] OP_ADD = 16'h002B;
   localparam logic [IMM_W-1:0] OP_SUB = 16'h002D;
   localparam logic [IMM_W-1:0] OP_MUL = 16'h002A;
   localparam logic [IMM_W-1:0] OP_DIV = 16'h002F;
   localparam logic [IMM_W-1:0] OP_AND = 16'h0026;
   localparam logic [IMM_W-1:0] OP_OR  = 16'h007C;
   localparam logic [IMM_W-1:0] OP_XOR = 16'h005E;
   localparam logic [IMM_W-1:0] OP_MOD = 16'h0025;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAIT
   } pes_state_type;

   typedef enum logic [1:0] {
      MD_MUL,
      MD_DIV,
      MD_MOD
   } md_op_type;

   typedef struct packed {
      logic              start;
      md_op_type         op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } md_rsp_type;

   function automatic logic known_op(input logic [IMM_W-1:0] code);
      return code == OP_ADD || code == OP_SUB || code == OP_MUL || code == OP_DIV ||
             code == OP_AND || code == OP_OR  || code == OP_XOR || code == OP_MOD;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pes_ram.sv -----
// pes_ram: generic single-write, single-read RAM with registered read data.
// Holds the operand stack. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/pes_muldiv.sv -----
// pes_muldiv: iterative multiply / divide / modulo unit, one bit per cycle
// over a single shared 34-bit adder. Depends on pes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pes_muldiv (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pes_pkg::md_req_type md_req,
   output      pes_pkg::md_rsp_type md_rsp
);

   localparam int DW = pes_pkg::DATA_W;

   // acc: product or partial remainder; sh: multiplicand or quotient;
   // opb: multiplier or divisor
   logic [DW-1:0]                acc_ff, acc_in;
   logic [DW-1:0]                sh_ff, sh_in;
   logic [DW-1:0]                opb_ff, opb_in;
   logic [pes_pkg::MD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   pes_pkg::md_op_type           op_ff, op_in;

   logic [DW:0]   shifted;
   logic [DW+1:0] add_a, add_b, sum;
   logic          add_sub;
   logic          no_borrow;

   always_comb begin
      shifted = {acc_ff, sh_ff[DW-1]};
      if (op_ff == pes_pkg::MD_MUL) begin
         add_a   = {2'b00, acc_ff};
         add_b   = {2'b00, sh_ff};
         add_sub = 1'b0;
      end else begin
         add_a   = {1'b0, shifted};
         add_b   = {2'b00, opb_ff};
         add_sub = 1'b1;
      end
      sum       = add_a + (add_sub ? ~add_b : add_b) + {{(DW+1){1'b0}}, add_sub};
      // top bit set means the trial subtraction went negative
      no_borrow = ~sum[DW+1];
   end

   always_comb begin
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opb_in  = opb_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      if (md_req.start) begin
         acc_in  = '0;
         sh_in   = md_req.a;
         opb_in  = md_req.b;
         op_in   = md_req.op;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (op_ff)
            pes_pkg::MD_MUL: begin
               if (opb_ff[0]) begin
                  acc_in = sum[DW-1:0];
               end
               sh_in  = {sh_ff[DW-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[DW-1:1]};
            end
            default: begin
               // restoring division step
               acc_in = no_borrow ? sum[DW-1:0] : shifted[DW-1:0];
               sh_in  = {sh_ff[DW-2:0], no_borrow};
            end
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pes_pkg::MD_CNT_W'(pes_pkg::MD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= pes_pkg::MD_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opb_ff <= opb_in;
   end

   assign md_rsp.done   = done_ff;
   assign md_rsp.result = (op_ff == pes_pkg::MD_DIV) ? sh_ff : acc_ff;

endmodule

`default_nettype wire

// ----- rtl/postfix_stack_evaluator.sv -----
// postfix_stack_evaluator: top level; sequencer, accumulator, stack control.
// Depends on pes_pkg, pes_ram and pes_muldiv.
//
//   channel | dir | tdata                                   | tuser
//   req     | in  | imm[15:0] long_value[47:16] var_value[79:48] | kind[2:0]
//   rsp     | out | value[31:0]                             | status[2:0]
//
// Operands, end markers, bad kinds and ignored items are handled in the idle state.
// + - & | ^ pass through the execute state: the stack RAM read is registered.
// * / % pass through the execute and wait states: 32 steps of the shared shift-add / restoring divider.
// Synchronous active-high reset clears control state; the stack needs no clear.
// req_tready is low while an operator runs, and while a result waits unless
// it is taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [79:0] req_tdata,   // imm[15:0], long_value[47:16], var_value[79:48]
   input  wire logic [2:0]  req_tuser,   // kind[2:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // value[31:0]
   output      logic [2:0]  rsp_tuser    // status[2:0]
);

   localparam int DW = pes_pkg::DATA_W;
   localparam int CW = pes_pkg::COUNT_W;
   localparam int AW = pes_pkg::STACK_AW;

   pes_pkg::pes_state_type state_ff, state_in;

   logic [DW-1:0]                  acc_ff, acc_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic                           started_ff, started_in;
   logic [pes_pkg::STATUS_W-1:0]   err_ff, err_in;
   logic [pes_pkg::IMM_W-1:0]      op_ff, op_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                  rsp_value_ff, rsp_value_in;
   logic [pes_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [pes_pkg::KIND_W-1:0] req_kind;
   logic [pes_pkg::IMM_W-1:0]  req_imm;
   logic [DW-1:0]              req_long;
   logic [DW-1:0]              req_var;
   logic                       accept;
   logic                       is_operand;
   logic [DW-1:0]              operand;
   logic                       op_go;
   logic                       divmod;
   logic [CW-1:0]              count_dec;

   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [DW-1:0] ram_rd_data;

   pes_pkg::md_req_type md_req;
   pes_pkg::md_rsp_type md_rsp;

   assign req_kind  = req_tuser;
   assign req_imm   = req_tdata[15:0];
   assign req_long  = req_tdata[47:16];
   assign req_var   = req_tdata[79:48];
   assign accept    = req_tvalid && req_tready;
   assign count_dec = count_ff - 1'b1;
   assign divmod    = (req_imm == pes_pkg::OP_DIV) || (req_imm == pes_pkg::OP_MOD);

   always_comb begin
      is_operand = 1'b1;
      operand    = req_var;
      case (req_kind) inside
         pes_pkg::KIND_VAR:   operand = req_var;
         pes_pkg::KIND_SHORT: operand = {{(DW - pes_pkg::IMM_W){1'b0}}, req_imm};
         pes_pkg::KIND_LONG:  operand = req_long;
         default:             is_operand = 1'b0;
      endcase
   end

   // an operator that passes every check and goes on to read the stack
   assign op_go = (req_kind == pes_pkg::KIND_OP) && (err_ff == pes_pkg::STS_OK) &&
                  started_ff && pes_pkg::known_op(req_imm) && (count_ff != '0) &&
                  !(divmod && (acc_ff == '0));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pes_pkg::S_IDLE: begin
            if (accept && op_go) begin
               state_in = pes_pkg::S_EXEC;
            end
         end
         pes_pkg::S_EXEC: begin
            case (op_ff) inside
               pes_pkg::OP_MUL, pes_pkg::OP_DIV, pes_pkg::OP_MOD: state_in = pes_pkg::S_WAIT;
               default: state_in = pes_pkg::S_IDLE;
            endcase
         end
         pes_pkg::S_WAIT: begin
            if (md_rsp.done) begin
               state_in = pes_pkg::S_IDLE;
            end
         end
         default: state_in = pes_pkg::S_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_tready   = 1'b0;
      ram_rd_en    = 1'b0;
      md_req.start = 1'b0;
      md_req.op    = pes_pkg::MD_MUL;
      md_req.a     = ram_rd_data;
      md_req.b     = acc_ff;
      unique case (state_ff)
         pes_pkg::S_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            ram_rd_en  = accept && op_go;
         end
         pes_pkg::S_EXEC: begin
            case (op_ff)
               pes_pkg::OP_MUL: begin
                  md_req.start = 1'b1;
                  md_req.op    = pes_pkg::MD_MUL;
               end
               pes_pkg::OP_DIV: begin
                  md_req.start = 1'b1;
                  md_req.op    = pes_pkg::MD_DIV;
               end
               pes_pkg::OP_MOD: begin
                  md_req.start = 1'b1;
                  md_req.op    = pes_pkg::MD_MOD;
               end
               default: md_req.start = 1'b0;
            endcase
         end
         pes_pkg::S_WAIT: begin
            req_tready = 1'b0;
         end
         default: req_tready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      acc_in        = acc_ff;
      count_in      = count_ff;
      started_in    = started_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;

      case (state_ff)
         pes_pkg::S_IDLE: begin
            if (accept) begin
               if (req_kind == pes_pkg::KIND_END) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = (err_ff != pes_pkg::STS_OK) ? '0 : acc_ff;
                  rsp_status_in = err_ff;
                  acc_in        = '0;
                  count_in      = '0;
                  started_in    = 1'b0;
                  err_in        = pes_pkg::STS_OK;
               end else if (err_ff == pes_pkg::STS_OK) begin
                  if (is_operand) begin
                     if (!started_ff) begin
                        acc_in     = operand;
                        started_in = 1'b1;
                     end else if (count_ff >= CW'(pes_pkg::STACK_DEPTH)) begin
                        err_in = pes_pkg::STS_OVERFLOW;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                        acc_in    = operand;
                     end
                  end else if (req_kind == pes_pkg::KIND_OP) begin
                     if (!started_ff) begin
                        err_in = pes_pkg::STS_LEADING_OP;
                     end else if (!pes_pkg::known_op(req_imm)) begin
                        err_in = pes_pkg::STS_BAD_OP;
                     end else if (count_ff == '0) begin
                        err_in = pes_pkg::STS_UNDERFLOW;
                     end else if (divmod && (acc_ff == '0)) begin
                        err_in = pes_pkg::STS_DIV_ZERO;
                     end else begin
                        count_in = count_dec;
                        op_in    = req_imm;
                     end
                  end else begin
                     err_in = pes_pkg::STS_BAD_KIND;
                  end
               end
            end
         end
         pes_pkg::S_EXEC: begin
            case (op_ff)
               pes_pkg::OP_ADD: acc_in = ram_rd_data + acc_ff;
               pes_pkg::OP_SUB: acc_in = ram_rd_data - acc_ff;
               pes_pkg::OP_AND: acc_in = ram_rd_data & acc_ff;
               pes_pkg::OP_OR:  acc_in = ram_rd_data | acc_ff;
               pes_pkg::OP_XOR: acc_in = ram_rd_data ^ acc_ff;
               default:         acc_in = acc_ff;
            endcase
         end
         pes_pkg::S_WAIT: begin
            if (md_rsp.done) begin
               acc_in = md_rsp.result;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pes_pkg::S_IDLE;
         acc_ff       <= '0;
         count_ff     <= '0;
         started_ff   <= 1'b0;
         err_ff       <= pes_pkg::STS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   pes_ram #(
      .WIDTH(DW),
      .DEPTH(pes_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(acc_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(count_dec[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   pes_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .md_req(md_req),
      .md_rsp(md_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == pes_pkg::S_IDLE)
      else $error("input taken while an operator runs");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pes_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != pes_pkg::STS_OK |-> rsp_tdata == '0)
      else $error("error result carries nonzero value");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> state_ff == pes_pkg::S_WAIT)
      else $error("multiply/divide finished outside wait state");

   a_start_exec: assert property (@(posedge clock) disable iff (reset)
      md_req.start |=> state_ff == pes_pkg::S_WAIT)
      else $error("multiply/divide started without wait");

endmodule

`default_nettype wire
